// ----- rtl/escaped_frame_deframer_core_macros.svh -----
// assertion macros for the escaped frame deframer checker
// no dependencies; included by the checker file only
`ifndef ESCAPED_FRAME_DEFRAMER_CORE_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_CORE_MACROS_SVH

// concurrent assertion, masked while reset is high
`define EFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define EFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/efd_pkg.sv -----
// shared types, byte codes and the limit clamp for the escaped frame deframer
// no dependencies
package efd_pkg;

   localparam int unsigned MAX_FRAME_DEFAULT = 2048;

   localparam logic [7:0] BYTE_START = 8'h02;
   localparam logic [7:0] BYTE_END   = 8'h03;
   localparam logic [7:0] BYTE_ESC   = 8'h1B;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   localparam int unsigned LEN_W  = 12;
   localparam int unsigned POS_W  = 11;
   localparam int unsigned BYTE_W = 8;

   localparam logic [LEN_W-1:0] LIMIT_RESET = 12'd1470;
   localparam logic [LEN_W-1:0] LEN_WRAP    = 12'hFFF;

   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic              done;
      logic [LEN_W-1:0]  len;
   } rsp_type;

   // zero acts as one, anything above the build limit acts as the build limit
   function automatic logic [LEN_W-1:0] efd_clamp(input logic [LEN_W-1:0] value,
                                                  input int unsigned max_frame);
      logic [LEN_W-1:0] lim;
      lim = value;
      if (value == '0) begin
         lim = LEN_W'(1);
      end else if (32'(value) > max_frame) begin
         lim = LEN_W'(max_frame);
      end
      return lim;
   endfunction

endpackage

// ----- rtl/efd_limit.sv -----
// frame length limit register, clamped on write
// depends on efd_pkg
module efd_limit #(
   parameter int unsigned MAX_FRAME = efd_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [efd_pkg::LEN_W-1:0] csr_data,
   output logic [efd_pkg::LEN_W-1:0] limit
);
   import efd_pkg::*;

   logic [LEN_W-1:0] limit_ff;
   logic [LEN_W-1:0] limit_in;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid) ? efd_clamp(csr_data, MAX_FRAME) : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= efd_clamp(LIMIT_RESET, MAX_FRAME);
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign limit = limit_ff;

endmodule

// ----- rtl/efd_step.sv -----
// input register, escape and count state, and per-byte decode
// depends on efd_pkg
module efd_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [efd_pkg::BYTE_W-1:0] in_byte,
   input  logic [efd_pkg::LEN_W-1:0]  limit,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output efd_pkg::rsp_type           dn_data
);
   import efd_pkg::*;

   logic              hold_valid_ff;
   logic              hold_valid_in;
   logic [BYTE_W-1:0] hold_byte_ff;
   logic [LEN_W-1:0]  count_ff;
   logic [LEN_W-1:0]  count_in;
   logic              esc_ff;
   logic              esc_in;
   logic              adv;
   logic              has_rsp;
   logic [LEN_W-1:0]  cnt_next;
   rsp_type           rsp;

   assign adv      = hold_valid_ff && dn_ready;
   assign in_ready = !hold_valid_ff || adv;
   assign cnt_next = count_ff + LEN_W'(1);

   always_comb begin
      rsp      = '0;
      has_rsp  = 1'b1;
      count_in = count_ff;
      esc_in   = 1'b0;
      if (!esc_ff && hold_byte_ff == BYTE_START) begin
         rsp.kind = KIND_RESTART;
         count_in = '0;
      end else if (!esc_ff && hold_byte_ff == BYTE_END) begin
         rsp.kind = KIND_END;
         rsp.done = 1'b1;
         rsp.len  = count_ff;
         count_in = '0;
      end else if (!esc_ff && hold_byte_ff == BYTE_ESC) begin
         has_rsp = 1'b0;
         esc_in  = 1'b1;
      end else begin
         rsp.kind = KIND_DATA;
         rsp.data = hold_byte_ff;
         rsp.pos  = count_ff[POS_W-1:0];
         if (cnt_next >= limit || cnt_next == '0) begin
            rsp.done = 1'b1;
            rsp.len  = (cnt_next == '0) ? LEN_WRAP : cnt_next;
            count_in = '0;
         end else begin
            count_in = cnt_next;
         end
      end
   end

   assign hold_valid_in = in_ready ? in_valid : hold_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
         esc_ff        <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (adv) begin
            count_ff <= count_in;
            esc_ff   <= esc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hold_byte_ff <= in_byte;
      end
   end

   assign dn_valid = adv && has_rsp;
   assign dn_data  = rsp;

endmodule

// ----- rtl/efd_skid.sv -----
// result register with a skid entry so upstream ready comes from a flop
// depends on efd_pkg
module efd_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             up_ready,
   input  efd_pkg::rsp_type push_data,
   output logic             out_valid,
   input  logic             out_ready,
   output efd_pkg::rsp_type out_data
);
   import efd_pkg::*;

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_ff;
   rsp_type out_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_ff;
   rsp_type skid_in;

   assign up_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && out_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push && !skid_valid_ff) begin
         if (!out_valid_in) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// ----- rtl/escaped_frame_deframer_core.sv -----
// escaped frame deframer: strips start/end delimiters and escape stuffing
// each accepted byte passes the input hold register, then the result register
// throughput: one byte per cycle while rsp is not stalled; escapes give no beat
// the skid entry in the result stage lets req_tready come from flops only
// synchronous active-high reset clears the count, escape flag and all valids,
// and loads the length limit with 1470 clamped to MAX_FRAME
module escaped_frame_deframer_core #(
   parameter int unsigned MAX_FRAME = efd_pkg::MAX_FRAME_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [18:8] byte_position,
                                    // [30:19] frame_length, [31] zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data     // [11:0] max_frame_length
);
   import efd_pkg::*;

   logic [LEN_W-1:0] limit;
   logic             dn_valid;
   logic             dn_ready;
   rsp_type          dn_data;
   rsp_type          out_data;

   efd_limit #(
      .MAX_FRAME (MAX_FRAME)
   ) u_limit (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .limit     (limit)
   );

   efd_step u_step (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .limit    (limit),
      .dn_valid (dn_valid),
      .dn_ready (dn_ready),
      .dn_data  (dn_data)
   );

   efd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (dn_valid),
      .up_ready  (dn_ready),
      .push_data (dn_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {1'b0, out_data.len, out_data.pos, out_data.data};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.done;

endmodule

// ----- rtl/efd_checker.sv -----
// port-level checks for the escaped frame deframer, bound to the top level
// depends on efd_pkg and escaped_frame_deframer_core_macros.svh
`include "escaped_frame_deframer_core_macros.svh"

module efd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import efd_pkg::*;

   // a restart never closes a frame, an end delimiter always does
   `EFD_ASSERT(a_restart_open, clock, reset, rsp_tvalid && rsp_tuser == KIND_RESTART |-> !rsp_tlast && rsp_tdata == '0, "restart beat with payload or close")
   `EFD_ASSERT(a_end_closes, clock, reset, rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast && rsp_tdata[18:0] == '0, "end beat not closing or carrying data")

   // length only reported on a closing beat
   `EFD_ASSERT(a_len_on_close, clock, reset, rsp_tvalid && !rsp_tlast |-> rsp_tdata[30:19] == '0, "frame length on non-closing beat")

   // a stalled beat holds
   `EFD_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled beat changed")

   // nothing leaves right after reset
   `EFD_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid, "beat valid after reset")

endmodule

bind escaped_frame_deframer_core efd_checker u_efd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
